@@ sv/octb_pkg.sv @@
// Shared types and character constants for the octal-to-binary text converter.
package octb_pkg;

  typedef logic [7:0] char_t;

  // Default longest token that is still converted
  localparam int MAX_DIGITS_DEF = 16;

  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_ONE     = 8'h31;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_COMMA   = 8'h2C;
  localparam char_t CH_NEWLINE = 8'h0A;

  // Upper five bits shared by the ASCII digits '0'..'7'
  localparam logic [4:0] OCT_PREFIX = 5'b00110;

endpackage

@@ sv/octal_token_to_binary_text_core.sv @@
// Top level: octal token to binary text converter with a one-character emitter.
//
// One input character is taken per transfer while the block sits in its idle
// state. A character that ends a token or a line (space, comma, newline or the
// end-of-input mark) starts the emitter when there is a token or newline to
// send; it sends one output character per cycle, while out_ready does not hold
// it off, from a single output register: an optional separating space, three
// characters per buffered digit and an optional newline. The input is not
// ready until the item's last character is in the output register; other
// items leave the input ready. Tokens of more than MAX_DIGITS digits, or
// holding any character that is not an octal digit, are dropped. last_of_run
// marks the final character of each item.
module octal_token_to_binary_text_core #(
  parameter int MAX_DIGITS = octb_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  octb_pkg::char_t in_char_in,
  input  logic           in_end_of_input,
  output logic           out_valid,
  input  logic           out_ready,
  output octb_pkg::char_t out_char_out,
  output logic           out_last_of_run
);
  import octb_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic          state_r, state_nxt;
  logic [2:0]    buf_r [MAX_DIGITS];
  logic [CW-1:0] count_r, count_nxt;
  logic          skip_r, skip_nxt;
  logic          line_has_r, line_has_nxt;

  // emitter plan
  logic          space_pend_r, space_pend_nxt;
  logic          nl_pend_r, nl_pend_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    bit_r, bit_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  char_t         out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  logic acc, step, line_end, sep, is_oct, flush, nl_now, wr_digit;
  logic [2:0] cur_digit;
  logic       cur_bit;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_last_of_run = out_last_r;

  assign acc  = in_valid && in_ready;
  assign step = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // classify the incoming character
  assign line_end = in_end_of_input || (in_char_in == CH_NEWLINE);
  assign sep      = line_end || (in_char_in == CH_SPACE) || (in_char_in == CH_COMMA);
  assign is_oct   = (in_char_in[7:3] == OCT_PREFIX);
  assign flush    = sep && !skip_r && (count_r != '0);
  assign nl_now   = line_end && (line_has_r || flush);
  assign wr_digit = acc && !sep && !skip_r && is_oct && (count_r < MAX_CNT);

  assign cur_digit = buf_r[idx_r[IW-1:0]];
  assign cur_bit   = cur_digit[bit_r];

  // token tracking and emitter sequencing
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    skip_nxt       = skip_r;
    line_has_nxt   = line_has_r;
    space_pend_nxt = space_pend_r;
    nl_pend_nxt    = nl_pend_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    bit_nxt        = bit_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;

    if (acc) begin
      if (sep) begin
        count_nxt      = '0;
        skip_nxt       = 1'b0;
        space_pend_nxt = flush && line_has_r;
        nl_pend_nxt    = nl_now;
        len_nxt        = flush ? count_r : '0;
        idx_nxt        = '0;
        bit_nxt        = 2'd2;
        if (line_end) begin
          line_has_nxt = 1'b0;
        end else if (flush) begin
          line_has_nxt = 1'b1;
        end
        if (flush || nl_now) begin
          state_nxt = ST_EMIT;
        end
      end else if (!skip_r) begin
        if (wr_digit) begin
          count_nxt = count_r + 1'b1;
        end else begin
          count_nxt = '0;
          skip_nxt  = 1'b1;
        end
      end
    end

    if (step) begin
      out_valid_nxt = 1'b1;
      if (space_pend_r) begin
        out_char_nxt   = CH_SPACE;
        out_last_nxt   = 1'b0;
        space_pend_nxt = 1'b0;
      end else if (idx_r < len_r) begin
        out_char_nxt = cur_bit ? CH_ONE : CH_ZERO;
        out_last_nxt = (idx_r == len_r - 1'b1) && (bit_r == 2'd0) && !nl_pend_r;
        if (bit_r == 2'd0) begin
          bit_nxt = 2'd2;
          idx_nxt = idx_r + 1'b1;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
        if (out_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end else begin
        out_char_nxt = CH_NEWLINE;
        out_last_nxt = 1'b1;
        nl_pend_nxt  = 1'b0;
        state_nxt    = ST_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      skip_r       <= 1'b0;
      line_has_r   <= 1'b0;
      space_pend_r <= 1'b0;
      nl_pend_r    <= 1'b0;
      len_r        <= '0;
      idx_r        <= '0;
      bit_r        <= 2'd2;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      skip_r       <= skip_nxt;
      line_has_r   <= line_has_nxt;
      space_pend_r <= space_pend_nxt;
      nl_pend_r    <= nl_pend_nxt;
      len_r        <= len_nxt;
      idx_r        <= idx_nxt;
      bit_r        <= bit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers and digit buffer
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (wr_digit) begin
      buf_r[count_r[IW-1:0]] <= in_char_in[2:0];
    end
  end

`ifndef SYNTHESIS
  // end of input leaves the tracking state cleared
  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_end_of_input |=> (count_r == '0) && !skip_r && !line_has_r)
    else $error("state not cleared after end of input");

  // digit count never passes the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("digit count overflow");

  // emitter always has something left to send
  a_emit_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (space_pend_r || nl_pend_r || (idx_r < len_r)))
    else $error("emitter active with nothing to send");

  // only binary digits, space and newline leave the block
  a_out_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CH_ZERO) || (out_char_r == CH_ONE) ||
                    (out_char_r == CH_SPACE) || (out_char_r == CH_NEWLINE))
    else $error("unexpected output character");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the octal token to binary text converter.
module testbench;
  import octb_pkg::*;

  localparam int MAX_DIGITS = MAX_DIGITS_DEF;
  localparam int RANDOM_ITEMS = 350;
  localparam int N_ROWS = 25;
  localparam int DRAIN_CYCLES = 60;
  localparam longint TIMEOUT_CYCLES = 2_000_000;

  // One output character and its end-of-item flag
  typedef struct packed {
    char_t ch;
    logic  last;
  } bin_char_t;

  // Directed row: a character sent reps times; where fixed, the text the
  // block must send for each of those transfers, right-aligned in txt
  typedef struct packed {
    char_t       ch;
    logic        eoi;
    logic [4:0]  reps;
    logic        fixed;
    logic [2:0]  n_txt;
    logic [31:0] txt;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  char_t in_char_in = 8'h00;
  logic  in_end_of_input = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  char_t out_char_out;
  logic  out_last_of_run;

  // Converter state as the predictor sees it
  logic [2:0]  oct_digits [MAX_DIGITS];
  int unsigned n_digits = 0;
  bit          dropping = 1'b0;
  bit          line_busy = 1'b0;

  char_t       run_chars [$];
  bin_char_t   pending_chars [$];
  bin_char_t   want;
  int unsigned errors = 0;
  int unsigned sent_items = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  stim_row_t dir_rows [N_ROWS] = '{
    '{8'hFF,      1'b1, 5'd1,  1'b1, 3'd0, 32'h0},   // end of input right after reset
    '{CH_ZERO,    1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{CH_SPACE,   1'b0, 5'd1,  1'b1, 3'd3, "000"},
    '{8'h37,      1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{CH_COMMA,   1'b0, 5'd1,  1'b1, 3'd4, " 111"},
    '{CH_COMMA,   1'b0, 5'd1,  1'b1, 3'd0, 32'h0},   // empty token
    '{CH_NEWLINE, 1'b0, 5'd1,  1'b1, 3'd1, "\n"},
    '{CH_NEWLINE, 1'b0, 5'd1,  1'b1, 3'd0, 32'h0},   // empty line
    '{8'h2F,      1'b0, 5'd1,  1'b1, 3'd0, 32'h0},   // just below '0'
    '{8'h35,      1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{CH_SPACE,   1'b0, 5'd1,  1'b1, 3'd0, 32'h0},   // dropped token
    '{8'h38,      1'b0, 5'd1,  1'b1, 3'd0, 32'h0},   // just above '7'
    '{CH_NEWLINE, 1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{CH_ONE,     1'b0, 5'd1,  1'b0, 3'd0, 32'h0},
    '{CH_SPACE,   1'b0, 5'd1,  1'b1, 3'd3, "001"},
    '{8'h33,      1'b0, 5'd16, 1'b0, 3'd0, 32'h0},   // longest token
    '{CH_NEWLINE, 1'b0, 5'd1,  1'b0, 3'd0, 32'h0},   // most results per item
    '{8'h32,      1'b0, 5'd17, 1'b1, 3'd0, 32'h0},   // one digit too many
    '{CH_COMMA,   1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{8'h00,      1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{CH_SPACE,   1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{8'h80,      1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{CH_NEWLINE, 1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{8'h37,      1'b0, 5'd1,  1'b1, 3'd0, 32'h0},
    '{8'h34,      1'b1, 5'd1,  1'b1, 3'd4, "111\n"}  // char ignored at end of input
  };

  octal_token_to_binary_text_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_in(in_char_in),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char_out(out_char_out),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  // Predict the characters one input transfer produces; updates state
  task automatic convert_item(input char_t ch, input logic eoi);
    logic line_end;
    logic sep;
    run_chars.delete();
    line_end = eoi || ch == CH_NEWLINE;
    sep = line_end || ch == CH_SPACE || ch == CH_COMMA;
    if (sep) begin
      // close the token: print it unless it was dropped or empty
      if (!dropping && n_digits != 0) begin
        if (line_busy) run_chars.push_back(CH_SPACE);
        line_busy = 1'b1;
        for (int i = 0; i < n_digits; i++) begin
          for (int b = 2; b >= 0; b--) begin
            run_chars.push_back(oct_digits[i][b] ? CH_ONE : CH_ZERO);
          end
        end
      end
      dropping = 1'b0;
      n_digits = 0;
      if (line_end) begin
        if (line_busy) run_chars.push_back(CH_NEWLINE);
        line_busy = 1'b0;
      end
    end else if (!dropping) begin
      if (ch >= CH_ZERO && ch <= CH_ZERO + 8'd7 && n_digits < MAX_DIGITS) begin
        oct_digits[n_digits] = 3'(ch - CH_ZERO);
        n_digits++;
      end else begin
        // bad character or overlong token
        n_digits = 0;
        dropping = 1'b1;
      end
    end
  endtask

  // Drive one input transfer and queue what it must produce
  task automatic send_item(input char_t ch, input logic eoi, input logic fixed = 1'b0,
                           input int n_txt = 0, input logic [31:0] txt = 32'h0);
    bin_char_t bc;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= ch;
    in_end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    convert_item(ch, eoi);
    if (fixed) begin
      run_chars.delete();
      for (int i = 0; i < n_txt; i++) run_chars.push_back(txt[8*(n_txt-1-i) +: 8]);
    end
    foreach (run_chars[i]) begin
      bc.ch = run_chars[i];
      bc.last = (i == run_chars.size() - 1);
      pending_chars.push_back(bc);
    end
    sent_items++;
  endtask

  task automatic send_sep();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) send_item(CH_SPACE, 1'b0);
    else if (pick < 7) send_item(CH_COMMA, 1'b0);
    else if (pick < 9) send_item(CH_NEWLINE, 1'b0);
    else send_item(char_t'($urandom_range(0, 255)), 1'b1);
  endtask

  // Mostly well-formed tokens with random digits; some broken, some noise
  task automatic send_token_group();
    int unsigned kind;
    int unsigned len;
    int unsigned bad_at;
    char_t ch;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(MAX_DIGITS - 1, MAX_DIGITS + 1);
      else len = $urandom_range(1, 4);
      bad_at = (kind < 60) ? len : $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
        if (i == bad_at) ch = char_t'($urandom_range(0, 255));
        else ch = CH_ZERO + char_t'($urandom_range(0, 7));
        send_item(ch, 1'b0);
      end
      send_sep();
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 3)) send_sep();
    end else if (kind < 92) begin
      send_item(char_t'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_item(char_t'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Result side: random back-pressure and in-order compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer char=%h last=%b",
                                    out_char_out, out_last_of_run));
        end else begin
          want = pending_chars.pop_front();
          if (out_char_out !== want.ch)
            report_mismatch($sformatf("char_out %h, expected %h", out_char_out, want.ch));
          if (out_last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %b, expected %b (char %h)",
                                      out_last_of_run, want.last, want.ch));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Stimulus
  initial begin
    int unsigned target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 17;
    rcv_idle_pct = 87;

    // directed table
    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        send_item(dir_rows[r].ch, dir_rows[r].eoi, dir_rows[r].fixed,
                  int'(dir_rows[r].n_txt), dir_rows[r].txt);
      end
    end

    // random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      target = N_ROWS + RANDOM_ITEMS * (ph + 1) / 3;
      if (ph == 1) begin
        snd_idle_pct = 87;
        rcv_idle_pct = 17;
        // hold off until the block has sent everything
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
      end else if (ph == 2) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      while (sent_items < target) send_token_group();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS octal_token_to_binary_text_core");
    end else begin
      $display("FAIL octal_token_to_binary_text_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("ERROR: timeout with %0d results pending", pending_chars.size());
    $display("FAIL octal_token_to_binary_text_core");
    $finish;
  end

endmodule
